@@ design/minplus_apsp_squaring_macros.svh @@
// ----------------------------------------------------------------------------
// minplus_apsp_squaring macros
// Assertion shorthands shared by the checker of the squaring block.
// ----------------------------------------------------------------------------
`ifndef MINPLUS_APSP_SQUARING_MACROS_SVH
`define MINPLUS_APSP_SQUARING_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property at every clock edge, reset included.
`define MPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg
// Shared codes, command and register types for the min-plus squaring block.
// ----------------------------------------------------------------------------
package mps_pkg;

	localparam int OP_W           = 2;
	localparam int IDX_W          = 6;
	localparam int DIST_W         = 16;
	localparam int NODE_CNT_W     = 7;
	localparam int STEP_W         = 3;
	localparam int IN_TDATA_W     = 32;
	localparam int OUT_TDATA_W    = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CMD_FIFO_DEPTH = 4;

	// Host operation codes
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INFINITY   = 1'd1;

	localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [DIST_W-1:0]     INFINITY_RST   = 16'hFFFF;

	// Result kinds
	localparam logic RES_READ = 1'b0;
	localparam logic RES_DONE = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_RUN,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic                in_range;
		logic [IDX_W-1:0]    row;
		logic [IDX_W-1:0]    column;
		logic [DIST_W-1:0]   distance;
	} cmd_t;

	typedef struct packed {
		logic [NODE_CNT_W-1:0] node_count;
		logic [DIST_W-1:0]     infinity;
	} cfg_regs_t;

	// Squarings needed to cover paths of up to nodes-1 hops: bit length of nodes-1.
	function automatic logic [STEP_W-1:0] squarings_for(input logic [NODE_CNT_W-1:0] nodes);
		logic [NODE_CNT_W-1:0] span;
		logic [STEP_W-1:0]     steps;
		span  = nodes - NODE_CNT_W'(1);
		steps = '0;
		for (int b = 0; b < NODE_CNT_W; b++) begin
			if (span[b]) begin
				steps = STEP_W'(b + 1);
			end
		end
		return steps;
	endfunction

endpackage

@@ design/mps_front.sv @@
// ----------------------------------------------------------------------------
// mps_front
// Decode host words into commands; drop unused codes and stray loads.
// ----------------------------------------------------------------------------
module mps_front import mps_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output logic                  push_valid,
	input  logic                  push_ready,
	output cmd_t                  push_cmd
);

	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  row;
	logic [IDX_W-1:0]  column;
	logic [DIST_W-1:0] distance;
	logic              in_range;
	logic              keep;
	cmd_kind_t         kind;

	assign op       = s_tdata[OP_W-1:0];
	assign row      = s_tdata[OP_W +: IDX_W];
	assign column   = s_tdata[OP_W+IDX_W +: IDX_W];
	assign distance = s_tdata[OP_W+2*IDX_W +: DIST_W];
	assign in_range = (32'(row) < 32'(MAX_NODES)) && (32'(column) < 32'(MAX_NODES));

	always_comb begin
		keep = 1'b0;
		kind = CMD_LOAD;
		unique case (op)
			OP_LOAD: begin
				kind = CMD_LOAD;
				keep = in_range;
			end
			OP_RUN: begin
				kind = CMD_RUN;
				keep = 1'b1;
			end
			OP_READ: begin
				kind = CMD_READ;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		push_cmd.kind     = kind;
		push_cmd.in_range = in_range;
		push_cmd.row      = row;
		push_cmd.column   = column;
		push_cmd.distance = distance;
	end

	// Take words whenever the queue has room; dropped words leave no trace.
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid && keep;

endmodule

@@ design/mps_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mps_cmd_fifo
// Short command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module mps_cmd_fifo import mps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);

	cmd_t             slot_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (PTR_W+1)'(CMD_FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/mps_engine.sv @@
// ----------------------------------------------------------------------------
// mps_engine
// Execute commands: matrix stores, squaring and copy sweeps, result output.
// ----------------------------------------------------------------------------
module mps_engine import mps_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int DIST_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_regs_t              cfg,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser
);

	localparam int IW    = $clog2(MAX_NODES);
	localparam int AW    = 2 * IW;
	localparam int CELLS = 1 << AW;
	localparam int DW    = DIST_BITS;
	localparam int SW    = DIST_BITS + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQ_DRAIN,
		ST_COPY,
		ST_CP_DRAIN,
		ST_DONE
	} state_t;

	logic [DW-1:0] dist_mem [CELLS];
	logic [DW-1:0] prod_mem [CELLS];

	state_t           state_q;
	logic [IW-1:0]    i_q, j_q, k_q;
	logic [IW-1:0]    n_last_q;
	logic [STEP_W-1:0] steps_q;
	logic [STEP_W-1:0] sq_count_q;

	logic [DW-1:0]    rd_a_q, rd_b_q, pr_q;
	logic             sq_valid_s1, sq_first_s1, sq_last_s1;
	logic [AW-1:0]    sq_addr_s1;
	logic             cp_valid_s1;
	logic [AW-1:0]    cp_addr_s1;
	logic [SW-1:0]    best_q;
	logic             res_valid_s1, res_kind_s1, res_mem_s1;
	logic             out_valid_q, out_kind_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                  s1_moves, s1_free, do_cmd, res_load;
	logic [AW-1:0]         cmd_addr, addr_a, addr_b, dist_waddr;
	logic                  sq_issue, rd_a_en, dist_we, prod_we;
	logic [DW-1:0]         dist_wdata, inf_dw;
	logic [SW-1:0]         sq_sum, sq_base, sq_min;
	logic [NODE_CNT_W-1:0] n_eff;
	logic [IW-1:0]         n_last_start;
	logic [STEP_W-1:0]     steps_start;
	logic                  i_last, j_last, k_last;

	assign s1_moves  = res_valid_s1 && (!out_valid_q || m_tready);
	assign s1_free   = !res_valid_s1 || s1_moves;
	assign cmd_ready = (state_q == ST_IDLE) && ((cmd.kind == CMD_LOAD) || s1_free);
	assign do_cmd    = cmd_valid && cmd_ready;
	assign res_load  = (do_cmd && (cmd.kind == CMD_READ)) || ((state_q == ST_DONE) && s1_free);
	assign cmd_addr  = {IW'(cmd.row), IW'(cmd.column)};
	assign inf_dw    = DW'(cfg.infinity);

	assign i_last = (i_q == n_last_q);
	assign j_last = (j_q == n_last_q);
	assign k_last = (k_q == n_last_q);

	// Clamp the node count into 1..MAX_NODES for a new run.
	always_comb begin
		if (cfg.node_count == '0) begin
			n_eff = NODE_CNT_W'(1);
		end else if (32'(cfg.node_count) > 32'(MAX_NODES)) begin
			n_eff = NODE_CNT_W'(MAX_NODES);
		end else begin
			n_eff = cfg.node_count;
		end
	end
	assign n_last_start = IW'(n_eff - NODE_CNT_W'(1));
	assign steps_start  = squarings_for(n_eff);

	// Port A serves host reads and A[i][k]; port B serves A[k][j].
	assign sq_issue = (state_q == ST_SQUARE);
	assign addr_a   = sq_issue ? {i_q, k_q} : cmd_addr;
	assign addr_b   = {k_q, j_q};
	assign rd_a_en  = sq_issue || (do_cmd && (cmd.kind == CMD_READ) && cmd.in_range);

	assign dist_we    = (do_cmd && (cmd.kind == CMD_LOAD) && cmd.in_range) || cp_valid_s1;
	assign dist_waddr = cp_valid_s1 ? cp_addr_s1 : cmd_addr;
	assign dist_wdata = cp_valid_s1 ? pr_q : DW'(cmd.distance);

	// One min-plus term per cycle; the running minimum never exceeds infinity.
	assign sq_sum  = SW'(rd_a_q) + SW'(rd_b_q);
	assign sq_base = sq_first_s1 ? SW'(inf_dw) : best_q;
	assign sq_min  = (sq_sum < sq_base) ? sq_sum : sq_base;
	assign prod_we = sq_valid_s1 && sq_last_s1;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= dist_mem[addr_a];
		end
		if (sq_issue) begin
			rd_b_q <= dist_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (prod_we) begin
			prod_mem[sq_addr_s1] <= sq_min[DW-1:0];
		end
		if (state_q == ST_COPY) begin
			pr_q <= prod_mem[{i_q, j_q}];
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		sq_first_s1 <= (k_q == '0);
		sq_last_s1  <= k_last;
		sq_addr_s1  <= {i_q, j_q};
		cp_addr_s1  <= {i_q, j_q};
		if (sq_valid_s1) begin
			best_q <= sq_min;
		end
		if (res_load) begin
			res_kind_s1 <= do_cmd ? RES_READ : RES_DONE;
			res_mem_s1  <= do_cmd && cmd.in_range;
		end
		if (s1_moves) begin
			out_kind_q <= res_kind_s1;
			out_data_q <= res_mem_s1 ? OUT_TDATA_W'(rd_a_q) : '0;
		end
	end

	// Sequencer and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			n_last_q     <= '0;
			steps_q      <= '0;
			sq_count_q   <= '0;
			sq_valid_s1  <= 1'b0;
			cp_valid_s1  <= 1'b0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			sq_valid_s1 <= (state_q == ST_SQUARE);
			cp_valid_s1 <= (state_q == ST_COPY);

			if (res_load) begin
				res_valid_s1 <= 1'b1;
			end else if (s1_moves) begin
				res_valid_s1 <= 1'b0;
			end

			if (s1_moves) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (do_cmd && (cmd.kind == CMD_RUN)) begin
						n_last_q   <= n_last_start;
						steps_q    <= steps_start;
						sq_count_q <= '0;
						i_q        <= '0;
						j_q        <= '0;
						k_q        <= '0;
						state_q    <= (steps_start == '0) ? ST_DONE : ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								i_q     <= '0;
								state_q <= ST_SQ_DRAIN;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SQ_DRAIN: begin
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							i_q     <= '0;
							state_q <= ST_CP_DRAIN;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_CP_DRAIN: begin
					if ((sq_count_q + STEP_W'(1)) == steps_q) begin
						sq_count_q <= '0;
						state_q    <= ST_DONE;
					end else begin
						sq_count_q <= sq_count_q + STEP_W'(1);
						state_q    <= ST_SQUARE;
					end
				end
				ST_DONE: begin
					if (s1_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

@@ design/minplus_apsp_squaring.sv @@
// ----------------------------------------------------------------------------
// minplus_apsp_squaring: all-pairs shortest paths by min-plus squaring
// Loads and reads go at one word per cycle when no run is busy and the result
// stream is not stalled; read data passes a store read register, then the output
// register. A run takes ceil(log2 n) passes of a squaring and a copy sweep, then
// the done word. Reset clears configuration, queue and sequencer, not the stores.
// ----------------------------------------------------------------------------
module minplus_apsp_squaring import mps_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int DIST_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation, row, column, distance_in
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // distance_out
	output logic                   m_tuser,   // result_kind
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIST_W-1:0]      cfg_data
);

	// Reset clears the configuration, the command queue, the sequencer and
	// the output valid flag. Both matrix stores keep whatever they hold and
	// must be loaded before they are read or squared.

	cfg_regs_t cfg_q;
	logic      push_valid, push_ready;
	cmd_t      push_cmd;
	logic      cmd_valid, cmd_ready;
	cmd_t      cmd;

	// Capture register writes; the host writes them only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count <= NODE_COUNT_RST;
			cfg_q.infinity   <= INFINITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_COUNT: cfg_q.node_count <= cfg_data[NODE_CNT_W-1:0];
				REG_INFINITY:   cfg_q.infinity   <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front: take every word the queue has room for, drop unused codes and
	// loads outside the store, and forward the rest as commands.
	mps_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Queue: let the host keep streaming while a read stalls on the output
	// or a run ties up the engine.
	mps_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_cmd    (cmd)
	);

	// Back: one load or unstalled read a cycle; a run holds the queue
	// until its done word has entered the result stage.
	mps_engine #(
		.MAX_NODES (MAX_NODES),
		.DIST_BITS (DIST_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

@@ design/mps_checker.sv @@
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks on the result stream of the squaring block.
// ----------------------------------------------------------------------------
`include "minplus_apsp_squaring_macros.svh"

module mps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// Hold a stalled result word unchanged.
	`MPS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")

	// Carry zero data with every run-finished word.
	`MPS_ASSERT_ALWAYS(a_done_zero, m_tvalid && m_tuser |-> m_tdata == 16'd0, "done word carries data")

	// Offer nothing once reset has been seen at an edge.
	`MPS_ASSERT_ALWAYS(a_reset_quiet, !arst_n && $past(!arst_n) |-> !m_tvalid, "result offered during reset")

endmodule

bind minplus_apsp_squaring mps_checker u_mps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: min-plus closure testbench
// Streams load, run and read words into minplus_apsp_squaring and checks each
// read and done word against a predictor that squares its own matrix copy.
// ----------------------------------------------------------------------------
module tb_top;
	import mps_pkg::*;

	localparam int MAX_NODES     = 64;
	localparam int CELLS         = MAX_NODES * MAX_NODES;
	// The fourth operation code has no meaning; the block drops it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS  = 1850;
	// Loads trail the last result word; give them time to land before a write.
	localparam int SETTLE_CYCLES = 16;
	// No word moves while a run over 17 nodes squares and copies.
	localparam int QUIET_LIMIT   = 100_000;
	// Larger squares make a run too slow; above this size only load and read.
	localparam int RUN_SIZE_CAP  = 17;

	typedef struct {
		logic              kind;
		logic [DIST_W-1:0] distance;
	} result_word_t;

	// Holds the distance matrix and register copies, predicts each result word
	// when its command is accepted and compares the words that come back.
	class closure_scoreboard;
		logic [DIST_W-1:0]     matrix [CELLS];
		logic [NODE_CNT_W-1:0] node_count;
		logic [DIST_W-1:0]     infinity;
		result_word_t          awaited_words [$];
		int                    faults;
		int                    reads_checked;
		int                    runs_checked;

		function new();
			node_count    = NODE_COUNT_RST;
			infinity      = INFINITY_RST;
			faults        = 0;
			reads_checked = 0;
			runs_checked  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] value);
			case (idx)
				REG_NODE_COUNT: node_count = value[NODE_CNT_W-1:0];
				REG_INFINITY:   infinity = value;
				default: ;
			endcase
		endfunction

		// Zero acts as one node; anything past the store acts as the full store.
		function int active_nodes();
			int n;
			n = node_count;
			if (n == 0) n = 1;
			if (n > MAX_NODES) n = MAX_NODES;
			return n;
		endfunction

		function int passes_for(int n);
			int steps;
			int reach;
			steps = 0;
			reach = 1;
			while (reach < n) begin
				reach = reach * 2;
				steps++;
			end
			return steps;
		endfunction

		// One min-plus squaring of the active square. Sums are one bit wider
		// than a distance; the minimum starts at infinity, so it never passes it.
		function void square_once(int n);
			logic [DIST_W-1:0] product [CELLS];
			logic [DIST_W:0]   best;
			logic [DIST_W:0]   path;
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					best = {1'b0, infinity};
					for (int k = 0; k < n; k++) begin
						path = {1'b0, matrix[i * MAX_NODES + k]}
							+ {1'b0, matrix[k * MAX_NODES + j]};
						if (path < best) best = path;
					end
					product[i * MAX_NODES + j] = best[DIST_W-1:0];
				end
			end
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					matrix[i * MAX_NODES + j] = product[i * MAX_NODES + j];
				end
			end
		endfunction

		function void note_input(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
				logic [IDX_W-1:0] col, logic [DIST_W-1:0] dist_val);
			int addr;
			int n;
			addr = int'(row) * MAX_NODES + int'(col);
			n    = active_nodes();
			case (op)
				OP_LOAD: matrix[addr] = dist_val;
				OP_RUN: begin
					repeat (passes_for(n)) square_once(n);
					awaited_words.push_back('{kind: RES_DONE, distance: '0});
				end
				OP_READ: awaited_words.push_back('{kind: RES_READ, distance: matrix[addr]});
				default: ;
			endcase
		endfunction

		function void check_result(logic kind, logic [DIST_W-1:0] dist_val);
			result_word_t want;
			if (awaited_words.size() == 0) begin
				faults++;
				if (faults <= 20)
					$display("%0t: stray result word: kind %0d distance %0d",
						$time, kind, dist_val);
				return;
			end
			want = awaited_words.pop_front();
			if (kind !== want.kind) begin
				faults++;
				if (faults <= 20)
					$display("%0t: result kind mismatch: expected %0d, got %0d",
						$time, want.kind, kind);
			end
			if (dist_val !== want.distance) begin
				faults++;
				if (faults <= 20)
					$display("%0t: distance mismatch: expected %0d, got %0d",
						$time, want.distance, dist_val);
			end
			if (want.kind == RES_DONE) runs_checked++;
			else reads_checked++;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DIST_W-1:0]      cfg_data;

	closure_scoreboard sb;

	// Entries loaded so far, as the stimulus sees them; reads and runs touch
	// only these, since an unwritten entry has no defined value.
	bit entry_loaded [CELLS];
	int loaded_cells [$];
	int counted_words;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	int setting_count;
	int largest_run;

	minplus_apsp_squaring #(
		.MAX_NODES(MAX_NODES),
		.DIST_BITS(DIST_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // operation, row, column, distance_in
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // distance_out
		.m_tuser  (m_tuser),   // result_kind
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random receiver stalls, both monitors and the quiet-cycle count. Values
	// read here at the edge are the ones the block saw at that edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[1:0], s_tdata[7:2], s_tdata[13:8], s_tdata[29:14]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word, idling first at random, and hold it until accepted.
	// Valid stays high on return so back-to-back words keep it up.
	task automatic send_word(input logic [OP_W-1:0] op, input int row, input int col,
			input logic [DIST_W-1:0] dist_val);
		int addr;
		addr = row * MAX_NODES + col;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, dist_val, IDX_W'(col), IDX_W'(row), op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_LOAD && !entry_loaded[addr]) begin
			entry_loaded[addr] = 1'b1;
			loaded_cells.push_back(addr);
		end
		if (op != OP_UNUSED) counted_words++;
	endtask

	// Write both registers on consecutive edges; the enable drops once.
	task automatic set_registers(input logic [NODE_CNT_W-1:0] nodes,
			input logic [DIST_W-1:0] inf);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NODE_COUNT;
		cfg_data  <= DIST_W'(nodes);
		@(posedge clk);
		cfg_index <= REG_INFINITY;
		cfg_data  <= inf;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_NODE_COUNT, DIST_W'(nodes));
		sb.write_reg(REG_INFINITY, inf);
		setting_count++;
	endtask

	// Drop valid, wait out every awaited word, then let trailing loads land.
	// The first edge lets the monitor note the last accepted word.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mix of zero, infinity, all ones, wide random and short edges that keep
	// most sums under infinity so real paths show up.
	function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] inf,
			input bit diagonal);
		if (diagonal && $urandom_range(0, 1)) return '0;
		case ($urandom_range(0, 9))
			0:       return inf;
			1:       return '1;
			2:       return '0;
			3, 4:    return DIST_W'($urandom);
			default: return DIST_W'($urandom_range(0, inf) >> $urandom_range(0, 3));
		endcase
	endfunction

	task automatic read_random_loaded();
		int addr;
		if (loaded_cells.size() == 0) return;
		addr = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
		send_word(OP_READ, addr / MAX_NODES, addr % MAX_NODES, DIST_W'($urandom));
	endtask

	task automatic load_anywhere(input logic [DIST_W-1:0] inf);
		send_word(OP_LOAD, $urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1),
			pick_distance(inf, 1'b0));
	endtask

	task automatic send_noise();
		send_word(OP_UNUSED, $urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1),
			DIST_W'($urandom));
	endtask

	// Occasional reads, stray loads and dropped words between the main ones.
	task automatic sprinkle(input logic [DIST_W-1:0] inf);
		case ($urandom_range(0, 19))
			0, 1:    read_random_loaded();
			2:       send_noise();
			3:       load_anywhere(inf);
			default: ;
		endcase
	endtask

	// One register setting: load the active square, run one to three times
	// with reads and reloads in between, then sweep the square. Squares too
	// large to run get a mix of loads and reads anywhere instead.
	task automatic closure_phase(input logic [NODE_CNT_W-1:0] nodes,
			input logic [DIST_W-1:0] inf);
		int n;
		set_registers(nodes, inf);
		n = sb.active_nodes();
		if (n > RUN_SIZE_CAP) begin
			repeat (40) begin
				case ($urandom_range(0, 9))
					0:          send_noise();
					1, 2, 3, 4: read_random_loaded();
					default:    load_anywhere(inf);
				endcase
			end
		end else begin
			if (n > largest_run) largest_run = n;
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c < n; c++) begin
					send_word(OP_LOAD, r, c, pick_distance(inf, r == c));
					sprinkle(inf);
				end
			end
			repeat ($urandom_range(1, 3)) begin
				send_word(OP_RUN, $urandom_range(0, MAX_NODES - 1),
					$urandom_range(0, MAX_NODES - 1), DIST_W'($urandom));
				repeat ($urandom_range(1, n + 2)) read_random_loaded();
				if ($urandom_range(0, 2) == 0)
					send_word(OP_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						pick_distance(inf, 1'b0));
				sprinkle(inf);
			end
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c < n; c++) begin
					send_word(OP_READ, r, c, DIST_W'($urandom));
				end
			end
		end
		drain();
	endtask

	// Watchdog: end the run when no word has moved for too long.
	initial begin
		@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		logic [NODE_CNT_W-1:0] nodes;
		logic [DIST_W-1:0]     inf;
		int                    random_start;
		int                    setting;
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 17;
		recv_idle_pct = 45;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner rows, columns and distances at the reset size of 64 nodes,
		// plus a dropped word with every field bit set.
		send_word(OP_LOAD, MAX_NODES - 1, MAX_NODES - 1, '1);
		send_word(OP_LOAD, 0, MAX_NODES - 1, '0);
		send_word(OP_LOAD, MAX_NODES - 1, 0, 16'hA5A5);
		send_word(OP_LOAD, 0, 0, 16'h5A5A);
		send_word(OP_READ, MAX_NODES - 1, MAX_NODES - 1, '0);
		send_word(OP_UNUSED, MAX_NODES - 1, MAX_NODES - 1, '1);
		send_word(OP_READ, 0, MAX_NODES - 1, '1);
		send_word(OP_READ, MAX_NODES - 1, 0, '0);
		send_word(OP_READ, 0, 0, '0);
		drain();

		// Two nodes with infinity at 100: one squaring. Edges of all ones clamp
		// to infinity, sums past 16 bits lose, and a two-hop loop wins.
		set_registers(7'd2, 16'd100);
		send_word(OP_LOAD, 0, 0, 16'd0);
		send_word(OP_LOAD, 0, 1, 16'hFFFF);
		send_word(OP_LOAD, 1, 0, 16'd70);
		send_word(OP_LOAD, 1, 1, 16'd30);
		send_word(OP_RUN, 0, 0, '0);
		send_word(OP_READ, 0, 0, '0);
		send_word(OP_READ, 0, 1, '0);
		send_word(OP_READ, 1, 0, '0);
		send_word(OP_READ, 1, 1, '0);
		drain();

		// Node count zero acts as one node, so the run squares nothing.
		set_registers(7'd0, '1);
		send_word(OP_RUN, 0, 0, '0);
		send_word(OP_READ, 0, 0, '0);
		drain();

		// Random settings. Idle pattern by thirds: sender light and receiver
		// heavy, then swapped, then no idling at all.
		random_start = counted_words;
		setting      = 0;
		while (counted_words - random_start < RANDOM_WORDS) begin
			case ((counted_words - random_start) * 3 / RANDOM_WORDS)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case ($urandom_range(0, 7))
				0:       inf = '0;
				1:       inf = '1;
				2, 3:    inf = DIST_W'($urandom);
				default: inf = DIST_W'($urandom_range(20, 4000));
			endcase
			// Hit the register extremes early, then draw mostly small squares.
			case (setting)
				0: nodes = 7'd127;
				1: nodes = 7'd1;
				2: nodes = 7'd64;
				default: begin
					case ($urandom_range(0, 15))
						0:       nodes = 7'd0;
						1:       nodes = 7'd1;
						2:       nodes = 7'd17;
						3:       nodes = 7'd12;
						4:       nodes = 7'd64;
						5:       nodes = NODE_CNT_W'($urandom_range(65, 127));
						default: nodes = NODE_CNT_W'($urandom_range(2, 8));
					endcase
				end
			endcase
			closure_phase(nodes, inf);
			setting++;
		end

		$display("tb_top: %0d words over %0d register settings, runs on up to %0d nodes",
			counted_words, setting_count, largest_run);
		$display("tb_top: %0d read words and %0d done words compared, %0d faults",
			sb.reads_checked, sb.runs_checked, sb.faults);
		if (sb.faults == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
